[rtl/bps_pkg.sv]
package bps_pkg;

  // Fixed field widths and the fraction scaling.
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = 16;
  localparam int COORD_W   = 32;
  localparam int SIDE_W    = 32;

  // Placement datapath widths.
  localparam int PROD_W = FRAC_W + SIDE_W;
  localparam int PSUM_W = PROD_W + 2;

  // Face selection datapath widths.
  localparam int AREA_W = 2 * SIDE_W;
  localparam int P_W    = AREA_W + 1;
  localparam int Q_W    = AREA_W + 2;
  localparam int S2_W   = AREA_W + 2;
  localparam int S4_W   = AREA_W + 3;
  localparam int TH_W   = AREA_W + 3;
  localparam int QL_W   = (Q_W + 1) / 2;
  localparam int QH_W   = Q_W - QL_W;
  localparam int PL_W   = FRAC_W + QL_W;
  localparam int PH_W   = FRAC_W + QH_W;
  localparam int PICK_W = FRAC_W + Q_W + 1;
  localparam int THS_W  = TH_W + FRAC_BITS;
  localparam int CMP_W  = ((PICK_W > THS_W) ? PICK_W : THS_W) + 1;

  localparam int NSTAGE = 8;
  localparam int NFACE  = 6;
  localparam int IDX_W  = 3;

  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W - 1){1'b1}}};

  typedef enum logic [2:0] {
    FACE_MIN_Z  = 3'd0,
    FACE_MAX_Z  = 3'd1,
    FACE_MIN_Y  = 3'd2,
    FACE_MAX_Y  = 3'd3,
    FACE_MIN_X  = 3'd4,
    FACE_MAX_X  = 3'd5,
    FACE_VOLUME = 3'd6
  } face_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW_X  = 3'd0,
    REG_LOW_Y  = 3'd1,
    REG_LOW_Z  = 3'd2,
    REG_HIGH_X = 3'd3,
    REG_HIGH_Y = 3'd4,
    REG_HIGH_Z = 3'd5,
    REG_MODE   = 3'd6
  } reg_idx_t;

  typedef logic [NSTAGE-1:0] stage_en_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] low_x;
    logic signed [COORD_W-1:0] low_y;
    logic signed [COORD_W-1:0] low_z;
    logic signed [COORD_W-1:0] high_x;
    logic signed [COORD_W-1:0] high_y;
    logic signed [COORD_W-1:0] high_z;
    logic                      surface_mode;
  } cfg_t;

  // Length of one box side; an inverted or empty side counts as zero.
  function automatic logic [SIDE_W-1:0] side_of(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
    logic [COORD_W:0] d;
    d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    return (d[COORD_W] || (d == '0)) ? '0 : d[SIDE_W-1:0];
  endfunction

endpackage

[rtl/bps_cfg.sv]
module bps_cfg
  import bps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_x        <= '0;
      cfg_r.low_y        <= '0;
      cfg_r.low_z        <= '0;
      cfg_r.high_x       <= COORD_W'(32'sd65536);
      cfg_r.high_y       <= COORD_W'(32'sd65536);
      cfg_r.high_z       <= COORD_W'(32'sd65536);
      cfg_r.surface_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW_X:  cfg_r.low_x        <= cfg_data;
        REG_LOW_Y:  cfg_r.low_y        <= cfg_data;
        REG_LOW_Z:  cfg_r.low_z        <= cfg_data;
        REG_HIGH_X: cfg_r.high_x       <= cfg_data;
        REG_HIGH_Y: cfg_r.high_y       <= cfg_data;
        REG_HIGH_Z: cfg_r.high_z       <= cfg_data;
        REG_MODE:   cfg_r.surface_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/bps_place.sv]
module bps_place
  import bps_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          stage_en,
  input  logic [FRAC_W-1:0]  frac,
  input  logic [SIDE_W-1:0]  side,
  input  logic [COORD_W-1:0] low,
  output logic [COORD_W-1:0] coord
);

  logic [PROD_W-1:0]  prod_r;
  logic [COORD_W-1:0] res_r [2:NSTAGE-2];
  logic [PROD_W-1:0]  off;
  logic [PSUM_W-1:0]  sum;
  logic               ovf;

  // Offset along the side, added to the low corner; only the top can overflow.
  always_comb begin
    off = prod_r >> FRAC_BITS;
    sum = {{(PSUM_W - COORD_W){low[COORD_W-1]}}, low} + {2'b00, off};
    ovf = !sum[PSUM_W-1] && (|sum[PSUM_W-2:COORD_W-1]);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      prod_r <= PROD_W'(frac) * PROD_W'(side);
    end
    if (stage_en[2]) begin
      res_r[2] <= ovf ? SAT_MAX : sum[COORD_W-1:0];
    end
  end

  for (genvar s = 3; s <= NSTAGE - 2; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        res_r[s] <= res_r[s-1];
      end
    end
  end

  assign coord = res_r[NSTAGE-2];

endmodule

[rtl/bps_face.sv]
module bps_face
  import bps_pkg::*;
(
  input  logic              clk,
  input  stage_en_t         stage_en,
  input  logic [FRAC_W-1:0] frac_pick,
  input  logic [SIDE_W-1:0] side_x,
  input  logic [SIDE_W-1:0] side_y,
  input  logic [SIDE_W-1:0] side_z,
  output face_t             face
);

  // Stage 1: face areas.
  logic [AREA_W-1:0] a0_1_r, a1_1_r, a2_1_r;
  logic [FRAC_W-1:0] f_1_r;
  // Stage 2: first partial sum.
  logic [AREA_W-1:0] a0_2_r, a2_2_r;
  logic [P_W-1:0]    p_2_r;
  logic [FRAC_W-1:0] f_2_r;
  // Stage 3: running sums; the total area is twice q.
  logic [AREA_W-1:0] a0_3_r;
  logic [P_W-1:0]    p_3_r;
  logic [Q_W-1:0]    q_3_r;
  logic [S2_W-1:0]   s2_3_r;
  logic [S4_W-1:0]   s4_3_r;
  logic [FRAC_W-1:0] f_3_r;
  // Stage 4: pick product split into two partial products.
  logic [AREA_W-1:0] a0_4_r;
  logic [P_W-1:0]    p_4_r;
  logic [Q_W-1:0]    q_4_r;
  logic [S2_W-1:0]   s2_4_r;
  logic [S4_W-1:0]   s4_4_r;
  logic [PL_W-1:0]   pl_4_r;
  logic [PH_W-1:0]   ph_4_r;
  // Stage 5: assembled pick value.
  logic [AREA_W-1:0] a0_5_r;
  logic [P_W-1:0]    p_5_r;
  logic [Q_W-1:0]    q_5_r;
  logic [S2_W-1:0]   s2_5_r;
  logic [S4_W-1:0]   s4_5_r;
  logic [CMP_W-1:0]  pick_5_r;
  // Stage 6: chosen face.
  face_t             face_6_r;

  logic [CMP_W-1:0]  th [NFACE];
  logic [NFACE-1:0]  below;
  face_t             face_nxt;
  logic [CMP_W-1:0]  pick_nxt;

  always_comb begin
    pick_nxt = ((CMP_W'(ph_4_r) << QL_W) + CMP_W'(pl_4_r)) << 1;
  end

  always_comb begin
    th[0] = CMP_W'(a0_5_r) << FRAC_BITS;
    th[1] = CMP_W'({a0_5_r, 1'b0}) << FRAC_BITS;
    th[2] = CMP_W'(s2_5_r) << FRAC_BITS;
    th[3] = CMP_W'({p_5_r, 1'b0}) << FRAC_BITS;
    th[4] = CMP_W'(s4_5_r) << FRAC_BITS;
    th[5] = CMP_W'({q_5_r, 1'b0}) << FRAC_BITS;
  end

  // The first running sum that the pick stays below wins; none means the last face.
  always_comb begin
    face_nxt = FACE_MAX_X;
    for (int k = NFACE - 1; k >= 0; k--) begin
      below[k] = pick_5_r < th[k];
      if (below[k]) begin
        face_nxt = face_t'(3'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      a0_1_r <= AREA_W'(side_x) * AREA_W'(side_y);
      a1_1_r <= AREA_W'(side_x) * AREA_W'(side_z);
      a2_1_r <= AREA_W'(side_y) * AREA_W'(side_z);
      f_1_r  <= frac_pick;
    end
    if (stage_en[2]) begin
      a0_2_r <= a0_1_r;
      a2_2_r <= a2_1_r;
      p_2_r  <= P_W'(a0_1_r) + P_W'(a1_1_r);
      f_2_r  <= f_1_r;
    end
    if (stage_en[3]) begin
      a0_3_r <= a0_2_r;
      p_3_r  <= p_2_r;
      q_3_r  <= Q_W'(p_2_r) + Q_W'(a2_2_r);
      s2_3_r <= S2_W'(p_2_r) + S2_W'(a0_2_r);
      s4_3_r <= S4_W'({p_2_r, 1'b0}) + S4_W'(a2_2_r);
      f_3_r  <= f_2_r;
    end
    if (stage_en[4]) begin
      a0_4_r <= a0_3_r;
      p_4_r  <= p_3_r;
      q_4_r  <= q_3_r;
      s2_4_r <= s2_3_r;
      s4_4_r <= s4_3_r;
      pl_4_r <= PL_W'(f_3_r) * PL_W'(q_3_r[QL_W-1:0]);
      ph_4_r <= PH_W'(f_3_r) * PH_W'(q_3_r[Q_W-1:QL_W]);
    end
    if (stage_en[5]) begin
      a0_5_r   <= a0_4_r;
      p_5_r    <= p_4_r;
      q_5_r    <= q_4_r;
      s2_5_r   <= s2_4_r;
      s4_5_r   <= s4_4_r;
      pick_5_r <= pick_nxt;
    end
    if (stage_en[6]) begin
      face_6_r <= face_nxt;
    end
  end

  assign face = face_6_r;

endmodule

[rtl/box_point_sampler.sv]
// Box point sampler: turns three uniform Q0.16 fractions into a point of an
// axis-aligned box, either anywhere in its volume or on one of its six faces.
// The input channel (in_valid, in_stall, in_frac_*) takes one request per cycle
// while in_stall is low; the result channel (out_valid, out_stall, out_point_*,
// out_face_code) returns one result for every request, in order.
// The box corners and the sampling mode sit in seven registers written over the
// cfg_ port, which is always ready; write them only while no request is in
// flight.
// A request is loaded into stage 0 and its result into the output register of the
// last stage. Throughput is one request per cycle while the receiver does not
// stall: the datapath is an eight-stage pipeline with one valid bit per stage, set
// by the multiplier and wide-compare depth of the surface face selection.
// When the receiver stalls, the result holds on the output and the stages behind
// it close up any empty slots; the input stalls only once every stage is full.
// Synchronous reset empties the pipeline and loads the unit cube in volume mode.
module box_point_sampler
  import bps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  // Request channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FRAC_W-1:0]  in_frac_first,
  input  logic [FRAC_W-1:0]  in_frac_second,
  input  logic [FRAC_W-1:0]  in_frac_third,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_point_x,
  output logic [COORD_W-1:0] out_point_y,
  output logic [COORD_W-1:0] out_point_z,
  output logic [2:0]         out_face_code
);

  cfg_t cfg;

  // One valid bit per stage; a stage loads when it is empty or the next one moves.
  logic [NSTAGE-1:0] v_r;
  stage_en_t         stage_en;

  // Stage 0 holds the fractions and the three box sides.
  logic [FRAC_W-1:0] f1_r, f2_r, f3_r;
  logic [SIDE_W-1:0] sx_r, sy_r, sz_r;

  // Candidate coordinates, one per fraction and axis pairing that any mode uses.
  logic [COORD_W-1:0] x_f1, x_f2, y_f2, y_f3, z_f3;
  face_t              face_sel;

  // Output stage.
  logic [COORD_W-1:0] px_r, py_r, pz_r;
  face_t              face_r;
  logic [COORD_W-1:0] px_nxt, py_nxt, pz_nxt;
  face_t              face_nxt;

  bps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stall chain, evaluated from the output backwards.
  always_comb begin
    stage_en[NSTAGE-1] = !v_r[NSTAGE-1] || !out_stall;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      stage_en[s] = !v_r[s] || stage_en[s+1];
    end
  end

  assign in_stall = !stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stage_en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s < NSTAGE; s++) begin
        if (stage_en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // The sides are taken from the corners as the request enters; the user must not
  // change the corners while it is in flight, and the block does not enforce this.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      f1_r <= in_frac_first;
      f2_r <= in_frac_second;
      f3_r <= in_frac_third;
      sx_r <= side_of(cfg.low_x, cfg.high_x);
      sy_r <= side_of(cfg.low_y, cfg.high_y);
      sz_r <= side_of(cfg.low_z, cfg.high_z);
    end
  end

  bps_place u_place_x_f1 (
    .clk (clk), .stage_en (stage_en), .frac (f1_r), .side (sx_r),
    .low (cfg.low_x), .coord (x_f1)
  );

  bps_place u_place_x_f2 (
    .clk (clk), .stage_en (stage_en), .frac (f2_r), .side (sx_r),
    .low (cfg.low_x), .coord (x_f2)
  );

  bps_place u_place_y_f2 (
    .clk (clk), .stage_en (stage_en), .frac (f2_r), .side (sy_r),
    .low (cfg.low_y), .coord (y_f2)
  );

  bps_place u_place_y_f3 (
    .clk (clk), .stage_en (stage_en), .frac (f3_r), .side (sy_r),
    .low (cfg.low_y), .coord (y_f3)
  );

  bps_place u_place_z_f3 (
    .clk (clk), .stage_en (stage_en), .frac (f3_r), .side (sz_r),
    .low (cfg.low_z), .coord (z_f3)
  );

  bps_face u_face (
    .clk       (clk),
    .stage_en  (stage_en),
    .frac_pick (f1_r),
    .side_x    (sx_r),
    .side_y    (sy_r),
    .side_z    (sz_r),
    .face      (face_sel)
  );

  // Final selection. In volume mode each axis takes its own fraction. On a face
  // the fixed axis sits at the matching corner and the other two axes take the
  // second and third fractions in x, y, z order.
  always_comb begin
    px_nxt   = x_f1;
    py_nxt   = y_f2;
    pz_nxt   = z_f3;
    face_nxt = FACE_VOLUME;
    if (cfg.surface_mode) begin
      face_nxt = face_sel;
      case (face_sel)
        FACE_MIN_Z, FACE_MAX_Z: begin
          px_nxt = x_f2;
          py_nxt = y_f3;
          pz_nxt = (face_sel == FACE_MIN_Z) ? cfg.low_z : cfg.high_z;
        end
        FACE_MIN_Y, FACE_MAX_Y: begin
          px_nxt = x_f2;
          py_nxt = (face_sel == FACE_MIN_Y) ? cfg.low_y : cfg.high_y;
          pz_nxt = z_f3;
        end
        default: begin
          px_nxt = (face_sel == FACE_MIN_X) ? cfg.low_x : cfg.high_x;
          py_nxt = y_f2;
          pz_nxt = z_f3;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[NSTAGE-1]) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      face_r <= face_nxt;
    end
  end

  assign out_valid     = v_r[NSTAGE-1];
  assign out_point_x   = px_r;
  assign out_point_y   = py_r;
  assign out_point_z   = pz_r;
  assign out_face_code = face_r;

  // The input is held off only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled while the pipeline has an empty stage");

  // A request taken at the input occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted request did not enter the pipeline");

  // The face code follows the sampling mode.
  a_mode_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cfg.surface_mode ? (face_r != FACE_VOLUME) : (face_r == FACE_VOLUME)))
    else $error("face code does not match the sampling mode");

  // A point on the low z face lies on that face's plane.
  a_z_plane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && face_r == FACE_MIN_Z) |-> (pz_r == cfg.low_z))
    else $error("point on the low z face is off its plane");

  // A point on the high x face lies on that face's plane.
  a_x_plane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && face_r == FACE_MAX_X) |-> (px_r == cfg.high_x))
    else $error("point on the high x face is off its plane");

endmodule
